@@ src/assert_macros.svh @@
// Assertion macros for the checker file of the queue block.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising clock edge, disabled while reset is low.
`define FQD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fifo queue check failed");

// Assertion sampled on the rising clock edge, checked during reset as well.
`define FQD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fifo queue check failed during reset");

`endif

@@ src/fqd_pkg.sv @@
// Package of the queue block: capacity, widths, command, status and kind codes.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package fqd_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [2:0] CMD_INIT = 3'd0;
  localparam logic [2:0] CMD_PUSH = 3'd1;
  localparam logic [2:0] CMD_POP  = 3'd2;
  localparam logic [2:0] CMD_DUMP = 3'd3;
  localparam logic [2:0] CMD_PEEK = 3'd4;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam logic [2:0] KIND_ACK    = 3'd0;
  localparam logic [2:0] KIND_POPPED = 3'd1;
  localparam logic [2:0] KIND_LISTED = 3'd2;
  localparam logic [2:0] KIND_NEWEST = 3'd3;
  localparam logic [2:0] KIND_OLDEST = 3'd4;

  typedef struct packed {
    logic [31:0]        tag;
    logic signed [31:0] age;
  } rec_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic wrap;
  } cell_ctl_t;

endpackage

@@ src/fqd_cell.sv @@
// One storage cell of the queue chain: holds one record and hands it down.
// Depends on fqd_pkg for the record and control types.
`timescale 1ns / 1ps

module fqd_cell (
  input  logic              clk,
  input  fqd_pkg::cell_ctl_t ctl,
  input  fqd_pkg::rec_t     push_rec,
  input  fqd_pkg::rec_t     next_rec,
  input  fqd_pkg::rec_t     head_rec,
  output fqd_pkg::rec_t     rec
);

  fqd_pkg::rec_t data_r;
  fqd_pkg::rec_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.load) begin
      data_nxt = push_rec;
    end else if (ctl.shift) begin
      data_nxt = ctl.wrap ? head_rec : next_rec;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign rec = data_r;

endmodule

@@ src/fifo_queue_with_dump.sv @@
// Top level of the record queue: control sequencer and a chain of storage cells.
// Depends on fqd_pkg and fqd_cell.
//
// Usage: commands enter on the in_ channel (in_valid, in_stall, in_command,
// in_name_tag, in_age_value); results leave on the out_ channel through one
// output register, so each result appears the cycle after it is produced.
// A transaction is taken when valid is high and stall is low.
// Init, push and pop give one result the cycle after acceptance. Peek gives
// two results (newest, then oldest). Dump gives count results, one per cycle
// while not stalled, oldest first, by rotating the cell chain; after the last
// one the chain is back in its original order. Pop, peek and dump on an empty
// queue give one empty acknowledgement. The block takes one command at a time:
// in_stall is high while a peek or dump is still streaming and while the
// output register holds a result that the receiver stalls. Unknown commands
// are taken and give no result. Init, push, pop and unknown codes go at one
// command per cycle while not stalled, set by the single output register; a
// peek or dump holds off the next command until its last result is loaded.
// Reset leaves the queue uninitialized and empty with no result pending; the
// record cells are not cleared. A stalled result holds until it is taken.
`timescale 1ns / 1ps

module fifo_queue_with_dump (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_command,
  input  logic [31:0]        in_name_tag,
  input  logic signed [31:0] in_age_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [2:0]         out_record_kind,
  output logic [31:0]        out_name_tag,
  output logic signed [31:0] out_age,
  output logic               out_last_of_run
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DUMP = 2'd1;
  localparam logic [1:0] S_PEEK = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic                       armed_r, armed_nxt;
  logic [fqd_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic [fqd_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  fqd_pkg::rec_t              newest_r, newest_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [1:0]                 out_status_r, out_status_nxt;
  logic [2:0]                 out_kind_r, out_kind_nxt;
  fqd_pkg::rec_t              out_rec_r, out_rec_nxt;
  logic                       out_last_r, out_last_nxt;

  logic                       out_load;
  logic                       accept;
  logic                       is_empty;
  logic                       is_full;
  logic                       push_en;
  logic                       shift_en;
  logic                       wrap_en;
  fqd_pkg::rec_t              push_rec;
  fqd_pkg::rec_t              cell_q [fqd_pkg::CAPACITY];
  fqd_pkg::cell_ctl_t         cell_ctl [fqd_pkg::CAPACITY];

  assign out_load = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_load;
  assign accept   = in_valid && !in_stall;
  assign is_empty = !armed_r || (count_r == '0);
  assign is_full  = !armed_r || (count_r == fqd_pkg::CNT_W'(fqd_pkg::CAPACITY));
  assign push_rec = '{tag: in_name_tag, age: in_age_value};

  always_comb begin
    state_nxt      = state_r;
    armed_nxt      = armed_r;
    count_nxt      = count_r;
    rem_nxt        = rem_r;
    newest_nxt     = newest_r;
    out_valid_nxt  = out_load ? 1'b0 : out_valid_r;
    out_status_nxt = out_status_r;
    out_kind_nxt   = out_kind_r;
    out_rec_nxt    = out_rec_r;
    out_last_nxt   = out_last_r;
    push_en        = 1'b0;
    shift_en       = 1'b0;
    wrap_en        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_command)
            fqd_pkg::CMD_INIT: begin
              armed_nxt      = 1'b1;
              count_nxt      = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = fqd_pkg::STAT_DONE;
              out_kind_nxt   = fqd_pkg::KIND_ACK;
              out_rec_nxt    = '0;
              out_last_nxt   = 1'b1;
            end
            fqd_pkg::CMD_PUSH: begin
              out_valid_nxt  = 1'b1;
              out_kind_nxt   = fqd_pkg::KIND_ACK;
              out_rec_nxt    = '0;
              out_last_nxt   = 1'b1;
              if (is_full) begin
                out_status_nxt = fqd_pkg::STAT_FULL;
              end else begin
                out_status_nxt = fqd_pkg::STAT_DONE;
                push_en        = 1'b1;
                newest_nxt     = push_rec;
                count_nxt      = count_r + fqd_pkg::CNT_W'(1);
              end
            end
            fqd_pkg::CMD_POP, fqd_pkg::CMD_DUMP, fqd_pkg::CMD_PEEK: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (is_empty) begin
                out_status_nxt = fqd_pkg::STAT_EMPTY;
                out_kind_nxt   = fqd_pkg::KIND_ACK;
                out_rec_nxt    = '0;
              end else begin
                out_status_nxt = fqd_pkg::STAT_DONE;
                if (in_command == fqd_pkg::CMD_POP) begin
                  out_kind_nxt = fqd_pkg::KIND_POPPED;
                  out_rec_nxt  = cell_q[0];
                  shift_en     = 1'b1;
                  count_nxt    = count_r - fqd_pkg::CNT_W'(1);
                end else if (in_command == fqd_pkg::CMD_DUMP) begin
                  out_kind_nxt = fqd_pkg::KIND_LISTED;
                  out_rec_nxt  = cell_q[0];
                  out_last_nxt = (count_r == fqd_pkg::CNT_W'(1));
                  shift_en     = 1'b1;
                  wrap_en      = 1'b1;
                  rem_nxt      = count_r - fqd_pkg::CNT_W'(1);
                  if (count_r != fqd_pkg::CNT_W'(1)) begin
                    state_nxt = S_DUMP;
                  end
                end else begin
                  out_kind_nxt = fqd_pkg::KIND_NEWEST;
                  out_rec_nxt  = newest_r;
                  out_last_nxt = 1'b0;
                  state_nxt    = S_PEEK;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_DUMP: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = fqd_pkg::STAT_DONE;
          out_kind_nxt   = fqd_pkg::KIND_LISTED;
          out_rec_nxt    = cell_q[0];
          out_last_nxt   = (rem_r == fqd_pkg::CNT_W'(1));
          shift_en       = 1'b1;
          wrap_en        = 1'b1;
          rem_nxt        = rem_r - fqd_pkg::CNT_W'(1);
          if (rem_r == fqd_pkg::CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_PEEK: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = fqd_pkg::STAT_DONE;
          out_kind_nxt   = fqd_pkg::KIND_OLDEST;
          out_rec_nxt    = cell_q[0];
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      armed_r     <= 1'b0;
      count_r     <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      armed_r     <= armed_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    newest_r     <= newest_nxt;
    out_status_r <= out_status_nxt;
    out_kind_r   <= out_kind_nxt;
    out_rec_r    <= out_rec_nxt;
    out_last_r   <= out_last_nxt;
  end

  for (genvar i = 0; i < fqd_pkg::CAPACITY; i++) begin : g_cell
    assign cell_ctl[i].load  = push_en && (count_r == fqd_pkg::CNT_W'(i));
    assign cell_ctl[i].shift = shift_en;
    assign cell_ctl[i].wrap  = wrap_en && (count_r == fqd_pkg::CNT_W'(i + 1));

    fqd_cell u_cell (
      .clk      (clk),
      .ctl      (cell_ctl[i]),
      .push_rec (push_rec),
      .next_rec (cell_q[(i + 1 < fqd_pkg::CAPACITY) ? i + 1 : i]),
      .head_rec (cell_q[0]),
      .rec      (cell_q[i])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_record_kind = out_kind_r;
  assign out_name_tag    = out_rec_r.tag;
  assign out_age         = out_rec_r.age;
  assign out_last_of_run = out_last_r;

endmodule

@@ src/fqd_checker.sv @@
// Port-level checker for the record queue, bound to the top level.
// Depends on fqd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fqd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic [2:0]         out_record_kind,
  input logic [31:0]        out_name_tag,
  input logic signed [31:0] out_age,
  input logic               out_last_of_run
);

  // A stalled result holds its valid and its payload.
  `FQD_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_record_kind) && $stable(out_name_tag) && $stable(out_age) && $stable(out_last_of_run))

  // An acknowledgement carries no record.
  `FQD_ASSERT(a_ack_empty, clk, rst_n, out_valid && (out_record_kind == fqd_pkg::KIND_ACK) |-> (out_name_tag == '0) && (out_age == '0))

  // A refused command gives a single acknowledgement that closes its run.
  `FQD_ASSERT(a_refused, clk, rst_n, out_valid && (out_status != fqd_pkg::STAT_DONE) |-> (out_record_kind == fqd_pkg::KIND_ACK) && out_last_of_run)

  // The newest record of a peek is always followed by the oldest one.
  `FQD_ASSERT(a_peek_pair, clk, rst_n, out_valid && !out_stall && (out_record_kind == fqd_pkg::KIND_NEWEST) |-> in_stall && !out_last_of_run ##1 out_valid && (out_record_kind == fqd_pkg::KIND_OLDEST))

  // No result is offered while reset is held.
  `FQD_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid)

endmodule

bind fifo_queue_with_dump fqd_checker u_fqd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_record_kind (out_record_kind),
  .out_name_tag    (out_name_tag),
  .out_age         (out_age),
  .out_last_of_run (out_last_of_run)
);

@@ tb/tb_fifo_queue_with_dump.sv @@
// Self-checking testbench for the record queue with dump: it drives commands,
// predicts every result from its own model of the queue and checks each field.
// Depends on fqd_pkg and the fifo_queue_with_dump RTL.
`timescale 1ns / 1ps

module tb_fifo_queue_with_dump;

  localparam logic [2:0] CMD_UNKNOWN_LO = 3'd5;
  localparam logic [2:0] CMD_UNKNOWN_HI = 3'd7;
  localparam int         IDLE_PCT       = 22;
  localparam int         STALL_LIMIT    = 2000;
  localparam int         RANDOM_ITEMS   = 360;

  typedef struct {
    logic [1:0]         status;
    logic [2:0]         kind;
    logic [31:0]        tag;
    logic signed [31:0] age;
    logic               last;
  } queue_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_command = fqd_pkg::CMD_INIT;
  logic [31:0]        in_name_tag = '0;
  logic signed [31:0] in_age_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic [2:0]         out_record_kind;
  logic [31:0]        out_name_tag;
  logic signed [31:0] out_age;
  logic               out_last_of_run;

  queue_result_t awaited_results[$];
  logic          model_armed = 1'b0;
  int            model_count;
  int            model_head;
  fqd_pkg::rec_t model_store[fqd_pkg::CAPACITY];

  logic no_idle = 1'b0;
  int   mismatch_count = 0;
  int   commands_sent = 0;
  int   results_checked = 0;
  int   longest_listing = 0;
  int   quiet_cycles = 0;

  fifo_queue_with_dump dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_name_tag    (in_name_tag),
    .in_age_value   (in_age_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_record_kind(out_record_kind),
    .out_name_tag   (out_name_tag),
    .out_age        (out_age),
    .out_last_of_run(out_last_of_run)
  );

  always #5 clk = ~clk;

  function automatic void add_awaited(input logic [1:0] status, input logic [2:0] kind,
                                      input fqd_pkg::rec_t rec, input logic last);
    queue_result_t res;
    res.status = status;
    res.kind   = kind;
    res.tag    = rec.tag;
    res.age    = rec.age;
    res.last   = last;
    awaited_results.push_back(res);
  endfunction

  function automatic void predict_queue(input logic [2:0] cmd, input logic [31:0] tag,
                                        input logic signed [31:0] age);
    fqd_pkg::rec_t none;
    fqd_pkg::rec_t pushed;
    none.tag   = '0;
    none.age   = '0;
    pushed.tag = tag;
    pushed.age = age;
    case (cmd)
      fqd_pkg::CMD_INIT: begin
        model_armed = 1'b1;
        model_count = 0;
        model_head  = 0;
        add_awaited(fqd_pkg::STAT_DONE, fqd_pkg::KIND_ACK, none, 1'b1);
      end
      fqd_pkg::CMD_PUSH: begin
        if (!model_armed || model_count >= fqd_pkg::CAPACITY) begin
          add_awaited(fqd_pkg::STAT_FULL, fqd_pkg::KIND_ACK, none, 1'b1);
        end else begin
          model_store[(model_head + model_count) % fqd_pkg::CAPACITY] = pushed;
          model_count++;
          add_awaited(fqd_pkg::STAT_DONE, fqd_pkg::KIND_ACK, none, 1'b1);
        end
      end
      fqd_pkg::CMD_POP: begin
        if (!model_armed || model_count == 0) begin
          add_awaited(fqd_pkg::STAT_EMPTY, fqd_pkg::KIND_ACK, none, 1'b1);
        end else begin
          add_awaited(fqd_pkg::STAT_DONE, fqd_pkg::KIND_POPPED, model_store[model_head],
                      1'b1);
          model_head = (model_head + 1) % fqd_pkg::CAPACITY;
          model_count--;
        end
      end
      fqd_pkg::CMD_DUMP: begin
        if (!model_armed || model_count == 0) begin
          add_awaited(fqd_pkg::STAT_EMPTY, fqd_pkg::KIND_ACK, none, 1'b1);
        end else begin
          for (int i = 0; i < model_count; i++)
            add_awaited(fqd_pkg::STAT_DONE, fqd_pkg::KIND_LISTED,
                        model_store[(model_head + i) % fqd_pkg::CAPACITY],
                        i == model_count - 1);
          if (model_count > longest_listing) longest_listing = model_count;
        end
      end
      fqd_pkg::CMD_PEEK: begin
        if (!model_armed || model_count == 0) begin
          add_awaited(fqd_pkg::STAT_EMPTY, fqd_pkg::KIND_ACK, none, 1'b1);
        end else begin
          add_awaited(fqd_pkg::STAT_DONE, fqd_pkg::KIND_NEWEST,
                      model_store[(model_head + model_count - 1) % fqd_pkg::CAPACITY],
                      1'b0);
          add_awaited(fqd_pkg::STAT_DONE, fqd_pkg::KIND_OLDEST, model_store[model_head],
                      1'b1);
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_command(input logic [2:0] cmd, input logic [31:0] tag,
                              input logic signed [31:0] age);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_name_tag  <= tag;
    in_age_value <= age;
    do @(posedge clk); while (in_stall);
    predict_queue(cmd, tag, age);
    commands_sent++;
  endtask

  task automatic send_random_push();
    send_command(fqd_pkg::CMD_PUSH, $urandom, $urandom);
  endtask

  task automatic send_unknown();
    send_command(3'($urandom_range(CMD_UNKNOWN_HI, CMD_UNKNOWN_LO)), $urandom, $urandom);
  endtask

  always @(posedge clk) begin
    queue_result_t want;
    out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (awaited_results.size() == 0) begin
        $error("unexpected result: status %0d kind %0d", out_status, out_record_kind);
        mismatch_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, got %0d", want.status, out_status);
          mismatch_count++;
        end
        if (out_record_kind !== want.kind) begin
          $error("out_record_kind: expected %0d, got %0d", want.kind, out_record_kind);
          mismatch_count++;
        end
        if (out_name_tag !== want.tag) begin
          $error("out_name_tag: expected %h, got %h", want.tag, out_name_tag);
          mismatch_count++;
        end
        if (out_age !== want.age) begin
          $error("out_age: expected %0d, got %0d", want.age, out_age);
          mismatch_count++;
        end
        if (out_last_of_run !== want.last) begin
          $error("out_last_of_run: expected %0d, got %0d", want.last, out_last_of_run);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic test_before_init();
    send_command(fqd_pkg::CMD_POP, $urandom, $urandom);
    send_command(fqd_pkg::CMD_PUSH, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
    send_command(fqd_pkg::CMD_DUMP, $urandom, $urandom);
    send_command(fqd_pkg::CMD_PEEK, $urandom, $urandom);
    send_command(CMD_UNKNOWN_LO, $urandom, $urandom);
    send_command(3'd6, $urandom, $urandom);
    send_command(CMD_UNKNOWN_HI, $urandom, $urandom);
  endtask

  task automatic test_basic_commands();
    send_command(fqd_pkg::CMD_INIT, $urandom, $urandom);
    send_command(fqd_pkg::CMD_POP, $urandom, $urandom);
    send_command(fqd_pkg::CMD_PEEK, $urandom, $urandom);
    send_command(fqd_pkg::CMD_DUMP, $urandom, $urandom);
    send_command(fqd_pkg::CMD_PUSH, 32'h0000_0000, 32'sh8000_0000);
    send_command(fqd_pkg::CMD_PUSH, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
    send_command(fqd_pkg::CMD_PEEK, $urandom, $urandom);
    send_command(fqd_pkg::CMD_DUMP, $urandom, $urandom);
    send_command(fqd_pkg::CMD_POP, $urandom, $urandom);
    send_command(fqd_pkg::CMD_PEEK, $urandom, $urandom);
    send_command(fqd_pkg::CMD_POP, $urandom, $urandom);
    send_command(fqd_pkg::CMD_PUSH, 32'hA5A5_5A5A, -32'sd1);
    send_command(fqd_pkg::CMD_INIT, $urandom, $urandom);
    send_command(fqd_pkg::CMD_DUMP, $urandom, $urandom);
  endtask

  task automatic test_fill_and_wrap();
    send_command(fqd_pkg::CMD_INIT, $urandom, $urandom);
    repeat (fqd_pkg::CAPACITY) send_random_push();
    send_random_push();
    send_command(fqd_pkg::CMD_DUMP, $urandom, $urandom);
    send_command(fqd_pkg::CMD_PEEK, $urandom, $urandom);
    repeat (5) send_command(fqd_pkg::CMD_POP, $urandom, $urandom);
    repeat (7) send_random_push();
    send_command(fqd_pkg::CMD_DUMP, $urandom, $urandom);
    send_command(fqd_pkg::CMD_PEEK, $urandom, $urandom);
    repeat (fqd_pkg::CAPACITY + 1) send_command(fqd_pkg::CMD_POP, $urandom, $urandom);
  endtask

  task automatic send_mixed(input int items, input bit fill_heavy);
    int pick;
    repeat (items) begin
      pick = $urandom_range(99);
      if (pick < 2) send_command(fqd_pkg::CMD_INIT, $urandom, $urandom);
      else if (pick < 5) send_unknown();
      else if (pick < 11) send_command(fqd_pkg::CMD_DUMP, $urandom, $urandom);
      else if (pick < 21) send_command(fqd_pkg::CMD_PEEK, $urandom, $urandom);
      else if (pick < (fill_heavy ? 76 : 46)) send_random_push();
      else send_command(fqd_pkg::CMD_POP, $urandom, $urandom);
    end
  endtask

  task automatic test_random_traffic();
    send_command(fqd_pkg::CMD_INIT, $urandom, $urandom);
    for (int phase = 0; phase < RANDOM_ITEMS / 60; phase++)
      send_mixed(60, phase % 2 == 0);
  endtask

  task automatic test_back_to_back();
    no_idle = 1'b1;
    send_command(fqd_pkg::CMD_INIT, $urandom, $urandom);
    repeat (20) send_random_push();
    send_command(fqd_pkg::CMD_DUMP, $urandom, $urandom);
    send_command(fqd_pkg::CMD_PEEK, $urandom, $urandom);
    repeat (5) send_command(fqd_pkg::CMD_POP, $urandom, $urandom);
    send_mixed(30, 1'b1);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_before_init();
    test_basic_commands();
    test_fill_and_wrap();
    test_back_to_back();
    test_random_traffic();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d commands and %0d checked results, longest dump %0d records.",
             commands_sent, results_checked, longest_listing);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
